/* design/scls_pkg.sv */
// ----------------------------------------------------------------------------
// scls_pkg
// shared types, message codes and character tables for the serial shell core
// ----------------------------------------------------------------------------
package scls_pkg;

   localparam int LINE_CAPACITY_DEF = 128;
   localparam int HEAD_DEPTH        = 8;
   localparam int ID_W              = 56;

   // message codes carried from the front end to the back end
   localparam logic [2:0] MSG_ECHO    = 3'd0;
   localparam logic [2:0] MSG_PROMPT  = 3'd1;
   localparam logic [2:0] MSG_CRLF    = 3'd2;
   localparam logic [2:0] MSG_CRLF_PR = 3'd3;
   localparam logic [2:0] MSG_SHOWID  = 3'd4;
   localparam logic [2:0] MSG_UNKNOWN = 3'd5;

   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_PROMPT = 8'h3E;
   localparam logic [7:0] CHAR_BS     = 8'h7F;
   localparam logic [7:0] CHAR_QUIT   = 8'h71;

   localparam logic [8*15-1:0] UNKNOWN_TEXT = "Unknown Command";

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic       led;
      logic       samp;
   } scls_entry_type;

   function automatic logic [4:0] msg_len(input logic [2:0] kind);
      logic [4:0] n;
      unique case (kind)
         MSG_ECHO:    n = 5'd1;
         MSG_PROMPT:  n = 5'd1;
         MSG_CRLF:    n = 5'd2;
         MSG_CRLF_PR: n = 5'd3;
         MSG_SHOWID:  n = 5'd12;
         MSG_UNKNOWN: n = 5'd20;
         default:     n = 5'd1;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] msg_char(input logic [2:0]      kind,
                                           input logic [4:0]      idx,
                                           input logic [7:0]      data,
                                           input logic [ID_W-1:0] id);
      logic [7:0] c;
      logic [4:0] k;
      logic [4:0] t;
      k = idx - 5'd2;
      t = 5'd16 - idx;
      c = CHAR_PROMPT;
      if (kind == MSG_ECHO) begin
         c = data;
      end else if (kind == MSG_PROMPT) begin
         c = CHAR_PROMPT;
      end else if (idx == 5'd0) begin
         c = CHAR_CR;
      end else if (idx == 5'd1) begin
         c = CHAR_LF;
      end else if (kind == MSG_SHOWID) begin
         if (idx <= 5'd8) begin
            c = id[{k[2:0], 3'b000} +: 8];
         end else if (idx == 5'd9) begin
            c = CHAR_CR;
         end else if (idx == 5'd10) begin
            c = CHAR_LF;
         end
      end else if (kind == MSG_UNKNOWN) begin
         if (idx <= 5'd16) begin
            c = UNKNOWN_TEXT[{t[3:0], 3'b000} +: 8];
         end else if (idx == 5'd17) begin
            c = CHAR_CR;
         end else if (idx == 5'd18) begin
            c = CHAR_LF;
         end
      end
      return c;
   endfunction

endpackage

/* design/scls_front.sv */
// ----------------------------------------------------------------------------
// scls_front
// line editor and command decoder; turns each accepted byte into at most one queued message
// ----------------------------------------------------------------------------
module scls_front
   import scls_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [7:0]     req_rx_byte,
   input  logic           q_full,
   output logic           push,
   output scls_entry_type push_entry
);

   localparam int LEN_W = $clog2(LINE_CAPACITY);

   localparam logic [55:0] WORD_SHOWID = 56'h00_64_69_77_6f_68_73;
   localparam logic [47:0] WORD_LIGHT  = 48'h00_74_68_67_69_6c;
   localparam logic [55:0] WORD_LEDON  = 56'h00_6e_6f_20_64_65_6c;
   localparam logic [63:0] WORD_LEDOFF = 64'h00_66_66_6f_20_64_65_6c;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       head_ff [HEAD_DEPTH];
   logic [7:0]       head_in [HEAD_DEPTH];
   logic             samp_ff, samp_in;
   logic             led_ff, led_in;
   logic [63:0]      line_vec;
   logic             accept;
   logic             len_small;
   logic [LEN_W-1:0] len_dec;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign len_small = len_ff < LEN_W'(HEAD_DEPTH);
   assign len_dec   = len_ff - LEN_W'(1);

   always_comb begin
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         line_vec[8*i +: 8] = (LEN_W'(i) < len_ff) ? head_ff[i] : 8'h00;
      end
   end

   always_comb begin
      len_in  = len_ff;
      head_in = head_ff;
      samp_in = samp_ff;
      led_in  = led_ff;
      push    = 1'b0;
      push_entry.kind = MSG_ECHO;
      push_entry.data = req_rx_byte;
      if (accept) begin
         if (samp_ff) begin
            if (req_rx_byte == CHAR_QUIT) begin
               push            = 1'b1;
               push_entry.kind = MSG_PROMPT;
               samp_in         = 1'b0;
            end
         end else if (req_rx_byte == CHAR_CR || req_rx_byte == CHAR_LF) begin
            push = 1'b1;
            if (line_vec[55:0] == WORD_SHOWID) begin
               push_entry.kind = MSG_SHOWID;
            end else if (line_vec[47:0] == WORD_LIGHT) begin
               push_entry.kind = MSG_CRLF;
               samp_in         = 1'b1;
            end else if (line_vec[55:0] == WORD_LEDON) begin
               push_entry.kind = MSG_CRLF_PR;
               led_in          = 1'b1;
            end else if (line_vec == WORD_LEDOFF) begin
               push_entry.kind = MSG_CRLF_PR;
               led_in          = 1'b0;
            end else if (len_ff == '0) begin
               push_entry.kind = MSG_CRLF_PR;
            end else begin
               push_entry.kind = MSG_UNKNOWN;
            end
            len_in = '0;
            for (int i = 0; i < HEAD_DEPTH; i++) begin
               head_in[i] = 8'h00;
            end
         end else if (req_rx_byte == CHAR_BS) begin
            if (len_ff != '0) begin
               push   = 1'b1;
               len_in = len_dec;
               if (len_dec < LEN_W'(HEAD_DEPTH)) begin
                  head_in[len_dec[2:0]] = 8'h00;
               end
            end
         end else begin
            push = 1'b1;
            if (len_ff < LEN_W'(LINE_CAPACITY - 1)) begin
               if (len_small) begin
                  head_in[len_ff[2:0]] = req_rx_byte;
               end
               len_in = len_ff + LEN_W'(1);
            end
         end
      end
      push_entry.led  = led_in;
      push_entry.samp = samp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         samp_ff <= 1'b0;
         led_ff  <= 1'b0;
         for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_ff[i] <= 8'h00;
         end
      end else begin
         len_ff  <= len_in;
         samp_ff <= samp_in;
         led_ff  <= led_in;
         head_ff <= head_in;
      end
   end

endmodule

/* design/scls_queue.sv */
// ----------------------------------------------------------------------------
// scls_queue
// two-entry message queue between the line editor and the transmitter
// ----------------------------------------------------------------------------
module scls_queue
   import scls_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  scls_entry_type push_entry,
   input  logic           pop,
   output scls_entry_type head_entry,
   output logic           full,
   output logic           empty
);

   scls_entry_type slot_ff [2];
   logic           wr_ff, wr_in;
   logic           rd_ff, rd_in;
   logic [1:0]     cnt_ff, cnt_in;

   assign full       = cnt_ff == 2'd2;
   assign empty      = cnt_ff == 2'd0;
   assign head_entry = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

/* design/scls_back.sv */
// ----------------------------------------------------------------------------
// scls_back
// message sequencer; sends the characters of one message per item
// ----------------------------------------------------------------------------
module scls_back
   import scls_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  scls_entry_type  q_head,
   output logic            pop,
   input  logic [ID_W-1:0] id_text,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_last,
   output logic            rsp_led_on,
   output logic            rsp_sampling_on
);

   scls_entry_type cur_ff, cur_in;
   logic           cur_valid_ff, cur_valid_in;
   logic [4:0]     idx_ff, idx_in;
   logic           valid_ff, valid_in;
   logic [7:0]     tx_ff, tx_in;
   logic           last_ff, last_in;
   logic           led_ff, led_in;
   logic           samp_ff, samp_in;
   logic           load;
   logic           is_last;

   assign pop     = !cur_valid_ff && !q_empty;
   assign load    = cur_valid_ff && (!valid_ff || !rsp_stall);
   assign is_last = idx_ff == (msg_len(cur_ff.kind) - 5'd1);

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      tx_in        = tx_ff;
      last_in      = last_ff;
      led_in       = led_ff;
      samp_in      = samp_ff;
      if (pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         idx_in       = 5'd0;
      end
      if (load) begin
         valid_in = 1'b1;
         tx_in    = msg_char(cur_ff.kind, idx_ff, cur_ff.data, id_text);
         last_in  = is_last;
         led_in   = cur_ff.led;
         samp_in  = cur_ff.samp;
         if (is_last) begin
            cur_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 5'd1;
         end
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
         idx_ff       <= 5'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         valid_ff     <= valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      tx_ff   <= tx_in;
      last_ff <= last_in;
      led_ff  <= led_in;
      samp_ff <= samp_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_tx_byte     = tx_ff;
   assign rsp_last        = last_ff;
   assign rsp_led_on      = led_ff;
   assign rsp_sampling_on = samp_ff;

endmodule

/* design/serial_command_line_shell_core.sv */
// ----------------------------------------------------------------------------
// serial_command_line_shell_core
// serial shell: line editing, command decode and reply generation
// path: an item taken passes the queue slot, the current-message register and the tx register before rsp
// throughput: one character per cycle while rsp_stall is low, plus a load step per message, so an
// item with n reply characters (1 to 20) holds the back end for its n characters and one load step
// a two-entry message queue lets new items be taken while replies drain
// reset: synchronous, clears the line, led level, sampling mode and id register
// ----------------------------------------------------------------------------
module serial_command_line_shell_core
   import scls_pkg::*;
#(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_rx_byte,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_last,
   output logic            rsp_led_on,
   output logic            rsp_sampling_on,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [ID_W-1:0] csr_id_text
);

   logic [ID_W-1:0] id_ff;
   logic            push;
   scls_entry_type  push_entry;
   scls_entry_type  q_head;
   logic            q_full;
   logic            q_empty;
   logic            pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff <= '0;
      end else if (csr_valid) begin
         id_ff <= csr_id_text;
      end
   end

   scls_front #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_rx_byte(req_rx_byte),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   scls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head_entry(q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   scls_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .pop            (pop),
      .id_text        (id_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last       (rsp_last),
      .rsp_led_on     (rsp_led_on),
      .rsp_sampling_on(rsp_sampling_on)
   );

endmodule

/* dv/tb_serial_command_line_shell_core.sv */
// ----------------------------------------------------------------------------
// tb_serial_command_line_shell_core
// self-checking bench for the serial shell core: drives received bytes with
// random gaps, predicts every transmit character from a behavioral shell
// model kept in a small scoreboard, and checks each reply field in order
// under random receiver stalls, one long receiver hold-off and id changes
// ----------------------------------------------------------------------------
module tb_serial_command_line_shell_core;
   timeunit 1ns;
   timeprecision 1ps;
   import scls_pkg::*;

   typedef struct {
      logic [7:0] tx_byte;
      logic       last;
      logic       led_on;
      logic       sampling_on;
   } shell_char_type;

   class shell_scoreboard;
      logic [ID_W-1:0] id_text;
      logic [7:0]      line_head [HEAD_DEPTH];
      int unsigned     line_len;
      bit              sampling_mode;
      bit              led_level;
      logic [7:0]      reply_q [$];
      shell_char_type  tx_expected_q [$];
      int              errors;

      function new();
         id_text       = '0;
         line_len      = 0;
         sampling_mode = 1'b0;
         led_level     = 1'b0;
         errors        = 0;
         foreach (line_head[i]) line_head[i] = 8'h00;
      endfunction

      function void set_id(input logic [ID_W-1:0] v);
         id_text = v;
      endfunction

      function int pending();
         return tx_expected_q.size();
      endfunction

      function bit line_matches(input string word);
         logic [7:0] w;
         logic [7:0] lc;
         for (int i = 0; i < HEAD_DEPTH; i++) begin
            w  = (i < word.len()) ? 8'(word[i]) : 8'h00;
            lc = (i < line_len) ? line_head[i] : 8'h00;
            if (lc != w) return 1'b0;
            if (w == 8'h00) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void push_text(input string s);
         for (int i = 0; i < s.len(); i++) reply_q.push_back(8'(s[i]));
      endfunction

      function void run_line();
         if (line_matches("showid")) begin
            for (int k = 0; k < 7; k++) reply_q.push_back(id_text[8*k +: 8]);
            reply_q.push_back(CHAR_CR);
            reply_q.push_back(CHAR_LF);
         end else if (line_matches("light")) begin
            sampling_mode = 1'b1;
            return;
         end else if (line_matches("led on")) begin
            led_level = 1'b1;
         end else if (line_matches("led off")) begin
            led_level = 1'b0;
         end else if (line_len != 0) begin
            push_text("Unknown Command");
            reply_q.push_back(CHAR_CR);
            reply_q.push_back(CHAR_LF);
         end
         reply_q.push_back(CHAR_PROMPT);
      endfunction

      // returns 0 when the byte is dropped in sampling mode
      function bit note_rx(input logic [7:0] c);
         shell_char_type e;
         bit             acted;
         acted = 1'b1;
         reply_q.delete();
         if (!sampling_mode) begin
            if (c == CHAR_CR || c == CHAR_LF) begin
               reply_q.push_back(CHAR_CR);
               reply_q.push_back(CHAR_LF);
               run_line();
               line_len = 0;
               foreach (line_head[i]) line_head[i] = 8'h00;
            end else if (c == CHAR_BS) begin
               if (line_len != 0) begin
                  reply_q.push_back(c);
                  line_len--;
                  if (line_len < HEAD_DEPTH) line_head[line_len] = 8'h00;
               end
            end else begin
               reply_q.push_back(c);
               if (line_len < LINE_CAPACITY_DEF - 1) begin
                  if (line_len < HEAD_DEPTH) line_head[line_len] = c;
                  line_len++;
               end
            end
         end else if (c == CHAR_QUIT) begin
            reply_q.push_back(CHAR_PROMPT);
            sampling_mode = 1'b0;
         end else begin
            acted = 1'b0;
         end
         foreach (reply_q[i]) begin
            e.tx_byte     = reply_q[i];
            e.last        = (i == reply_q.size() - 1);
            e.led_on      = led_level;
            e.sampling_on = sampling_mode;
            tx_expected_q.push_back(e);
         end
         return acted;
      endfunction

      function void check_tx(input logic [7:0] tx_byte, input logic last,
                             input logic led_on, input logic sampling_on);
         shell_char_type e;
         if (tx_expected_q.size() == 0) begin
            $error("unexpected item: tx_byte %h", tx_byte);
            errors++;
            return;
         end
         e = tx_expected_q.pop_front();
         if (tx_byte !== e.tx_byte) begin
            $error("tx_byte: expected %h actual %h", e.tx_byte, tx_byte);
            errors++;
         end
         if (last !== e.last) begin
            $error("last: expected %b actual %b", e.last, last);
            errors++;
         end
         if (led_on !== e.led_on) begin
            $error("led_on: expected %b actual %b", e.led_on, led_on);
            errors++;
         end
         if (sampling_on !== e.sampling_on) begin
            $error("sampling_on: expected %b actual %b", e.sampling_on, sampling_on);
            errors++;
         end
      endfunction
   endclass

   logic            clock           = 1'b0;
   logic            reset           = 1'b1;
   logic            req_valid       = 1'b0;
   logic            req_stall;
   logic [7:0]      req_rx_byte     = 8'h00;
   logic            rsp_valid;
   logic            rsp_stall       = 1'b0;
   logic [7:0]      rsp_tx_byte;
   logic            rsp_last;
   logic            rsp_led_on;
   logic            rsp_sampling_on;
   logic            csr_valid       = 1'b0;
   logic            csr_ready;
   logic [ID_W-1:0] csr_id_text     = '0;

   shell_scoreboard sb = new();
   bit              quiet       = 1'b0;
   int              hold_left   = 0;
   int              acted_items = 0;

   serial_command_line_shell_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last        (rsp_last),
      .rsp_led_on      (rsp_led_on),
      .rsp_sampling_on (rsp_sampling_on),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_id_text     (csr_id_text)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("[serial_command_line_shell_core] ERROR");
      $finish;
   end

   // receiver side stalls, with a counted hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 27);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_tx(rsp_tx_byte, rsp_last, rsp_led_on, rsp_sampling_on);
      end
   end

   task automatic send_item(input logic [7:0] b);
      while (!quiet && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      if (sb.note_rx(b)) acted_items++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(8'(s[i]));
   endtask

   task automatic write_id(input logic [ID_W-1:0] v);
      csr_valid   <= 1'b1;
      csr_id_text <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_id(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic send_end_of_line();
      send_item($urandom_range(1) ? CHAR_CR : CHAR_LF);
   endtask

   task automatic type_word(input string s);
      for (int i = 0; i < s.len(); i++) begin
         if ($urandom_range(99) < 10) begin
            send_item(8'($urandom_range(8'h7E, 8'h20)));
            send_item(CHAR_BS);
         end
         send_item(8'(s[i]));
      end
   endtask

   task automatic fill_line();
      int n;
      n = $urandom_range(140, 130);
      for (int i = 0; i < n; i++) send_item(8'($urandom_range(8'h7A, 8'h61)));
      send_item(CHAR_BS);
      send_item(8'h41);
      send_item(8'h42);
      send_end_of_line();
   endtask

   task automatic shell_traffic(input int n);
      string words [8] = '{"showid", "light", "led on", "led off", "",
                           "show", "led onn", "lights"};
      int    target;
      int    pick;
      target = acted_items + n;
      while (acted_items < target) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            type_word(words[$urandom_range(7)]);
            send_end_of_line();
            if (sb.sampling_mode) begin
               repeat ($urandom_range(3)) send_item(8'($urandom_range(255)));
               send_item(CHAR_QUIT);
            end
         end else if (pick < 70) begin
            repeat ($urandom_range(12, 1)) send_item(8'($urandom_range(8'h7E, 8'h20)));
            send_end_of_line();
         end else if (pick < 78) begin
            repeat ($urandom_range(3, 1)) send_item(CHAR_BS);
         end else if (pick < 90) begin
            send_item(8'($urandom_range(255)));
         end else if (pick < 95) begin
            send_text(words[$urandom_range(3)]);
            send_item(8'h00);
            repeat ($urandom_range(3)) send_item(8'($urandom_range(8'h7E, 8'h20)));
            send_end_of_line();
         end else begin
            repeat ($urandom_range(3, 1)) send_item(8'h00);
            send_end_of_line();
         end
      end
   endtask

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);

      // "ABCDEFG", first character in the low byte
      write_id(56'h47_46_45_44_43_42_41);
      send_item(CHAR_BS);
      send_item(CHAR_CR);
      send_text("showid");
      send_item(CHAR_CR);
      send_text("led on");
      send_item(CHAR_LF);
      send_text("light");
      send_item(CHAR_CR);
      send_item(8'h61);
      send_item(CHAR_QUIT);
      send_item(8'hFF);
      send_item(8'h00);
      send_item(CHAR_CR);
      drain_replies();

      write_id({ID_W{1'b1}});
      hold_left = 300;
      shell_traffic(35);
      drain_replies();

      write_id('0);
      quiet = 1'b1;
      shell_traffic(35);
      quiet = 1'b0;
      drain_replies();

      write_id(ID_W'({$urandom(), $urandom()}));
      fill_line();
      shell_traffic(35);
      drain_replies();

      write_id(ID_W'({$urandom(), $urandom()}));
      shell_traffic(35);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[serial_command_line_shell_core] OK");
      end else begin
         $display("[serial_command_line_shell_core] ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/scls_pkg.sv
design/scls_front.sv
design/scls_queue.sv
design/scls_back.sv
design/serial_command_line_shell_core.sv
dv/tb_serial_command_line_shell_core.sv
